### design/rpct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpct_pkg
// Shared constants, types and helpers for the raster to page-column transpose.
// ----------------------------------------------------------------------------
package rpct_pkg;

	// image limits
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int STORE_DEPTH = (MAX_WIDTH + 7) / 8;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BPR_W       = ADDR_W + 1;
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int PAGE_W      = ROW_W - 3;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ENTRY_W     = 64;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// burst handed from the merge stage to the column emitter
	typedef struct packed {
		logic [ENTRY_W-1:0] data;
		logic [COL_W-1:0]   col;
		logic [PAGE_W-1:0]  page;
		logic [2:0]         left;
	} em_load_t;

	// store write request
	typedef struct packed {
		logic               en;
		logic [ADDR_W-1:0]  addr;
		logic [ENTRY_W-1:0] data;
	} st_wr_t;

	// zero reads as one, anything above the limit saturates
	function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		begin
			if (v == '0) begin
				r = CFG_W'(1);
			end else if (v > hi) begin
				r = hi;
			end else begin
				r = v;
			end
			return r;
		end
	endfunction

endpackage

### design/raster_to_page_column_transpose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_to_page_column_transpose
// Packed 1-bit raster rows in, inverted page-column bytes out.
//
// Raster words enter on raster_valid/raster_ready, one byte of a row each,
// MSB leftmost. Eight rows form a page; on the last row of a page each word
// completes up to eight columns, sent on column_valid/column_ready one word
// per cycle while column_ready is high, with column and page, last_of_burst
// on the final one. Columns at or past image_width are skipped, an incomplete
// final page is never sent. Registers (cfg_valid/cfg_ready, cfg_index,
// cfg_data) are to be written only while the block is idle, which the block
// does not enforce; cfg_ready is always high. Throughput: one raster word per
// cycle on rows that send nothing; on the last row of a page a word waits in
// the merge stage until the emitter is free, so words go no faster than their
// columns (up to eight) leave its single output port. An accepted word passes
// the store read and merge stage register, then the emitter load, before its
// first column word. Store read, merge and write form a loop, same-entry words
// are forwarded. Reset clears the counters and registers (128 x 128); the
// store needs no clearing since row 0 of a page overwrites its entry. A
// stalled receiver holds the emitter, and raster_ready drops once a second burst waits.
module raster_to_page_column_transpose
	import rpct_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 raster_valid,
	output logic                 raster_ready,
	input  logic [7:0]           raster_byte,
	output logic                 column_valid,
	input  logic                 column_ready,
	output logic [7:0]           column_byte,
	output logic [COL_W-1:0]     column_index,
	output logic [PAGE_W-1:0]    page_index,
	output logic                 last_of_burst
);

	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;
	logic [ADDR_W-1:0]  byte_q;
	logic [ROW_W-1:0]   row_q;
	logic [CFG_W-1:0]   w_c;
	logic [CFG_W-1:0]   h_c;
	logic [CFG_W-1:0]   w_sum;
	logic [BPR_W-1:0]   bpr;
	logic [BPR_W-1:0]   byte_p1;
	logic [CFG_W-1:0]   row_p1;
	logic               accept;
	logic               valid_s1;
	logic               do_s1;
	logic [2:0]         bit_s1;
	logic [ADDR_W-1:0]  b_s1;
	logic [PAGE_W-1:0]  page_s1;
	logic [7:0]         pix_s1;
	logic               fwd_s1;
	logic [ENTRY_W-1:0] fwd_data_s1;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] old_e;
	logic [ENTRY_W-1:0] merged;
	logic [CFG_W-1:0]   rem;
	logic               rem_ge8;
	logic [2:0]         left;
	logic               emit_s1;
	logic               s1_go;
	logic               em_free;
	em_load_t           em_load;
	st_wr_t             st_wr;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(128);
			height_q <= CFG_W'(128);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective geometry
	assign w_c     = clamp_reg(width_q, CFG_W'(MAX_WIDTH));
	assign h_c     = clamp_reg(height_q, CFG_W'(MAX_HEIGHT));
	assign w_sum   = w_c + CFG_W'(7);
	assign bpr     = w_sum[CFG_W-1:3];
	assign byte_p1 = {1'b0, byte_q} + BPR_W'(1);
	assign row_p1  = {1'b0, row_q} + CFG_W'(1);

	// input handshake
	assign raster_ready = !valid_s1 || s1_go;
	assign accept       = raster_valid && raster_ready;

	// byte and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (byte_p1 >= bpr) begin
				byte_q <= '0;
				row_q  <= (row_p1 >= h_c) ? '0 : row_p1[ROW_W-1:0];
			end else begin
				byte_q <= byte_p1[ADDR_W-1:0];
			end
		end
	end

	// merge stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	// merge stage payload, forward a write that raced the read
	always_ff @(posedge clk) begin
		if (accept) begin
			do_s1       <= ({1'b0, byte_q} < bpr);
			bit_s1      <= row_q[2:0];
			b_s1        <= byte_q;
			page_s1     <= row_q[ROW_W-1:3];
			pix_s1      <= raster_byte;
			fwd_s1      <= st_wr.en && (b_s1 == byte_q);
			fwd_data_s1 <= merged;
		end
	end

	rpct_store u_store (
		.clk     (clk),
		.wr      (st_wr),
		.rd_en   (accept),
		.rd_addr (byte_q),
		.rd_data (rd_data)
	);

	// columns of this byte inside the image
	assign rem     = w_c - {1'b0, b_s1, 3'b000};
	assign rem_ge8 = |rem[CFG_W-1:3];
	assign left    = rem_ge8 ? 3'd7 : (rem[2:0] - 3'd1);

	// set the row bit of every white valid pixel
	always_comb begin
		old_e = (bit_s1 == 3'd0) ? '0 : (fwd_s1 ? fwd_data_s1 : rd_data);
		for (int k = 0; k < 8; k++) begin
			if ((rem_ge8 || (3'(k) < rem[2:0])) && !pix_s1[7-k]) begin
				merged[8*k +: 8] = old_e[8*k +: 8] | (8'h01 << bit_s1);
			end else begin
				merged[8*k +: 8] = old_e[8*k +: 8];
			end
		end
	end

	// write back, hand a finished page byte to the emitter
	assign emit_s1 = do_s1 && (bit_s1 == 3'd7);
	assign s1_go   = valid_s1 && (!emit_s1 || em_free);

	assign st_wr.en   = s1_go && do_s1;
	assign st_wr.addr = b_s1;
	assign st_wr.data = merged;

	assign em_load.data = merged;
	assign em_load.col  = {b_s1, 3'b000};
	assign em_load.page = page_s1;
	assign em_load.left = left;

	rpct_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_en       (s1_go && emit_s1),
		.load          (em_load),
		.free          (em_free),
		.column_valid  (column_valid),
		.column_ready  (column_ready),
		.column_byte   (column_byte),
		.column_index  (column_index),
		.page_index    (page_index),
		.last_of_burst (last_of_burst)
	);

`ifndef SYNTHESIS
	// a forwarded entry only exists for a word in the merge stage
	a_fwd_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 && !valid_s1 |-> !st_wr.en)
		else $error("store written with no word in merge stage");

	// a stalled merge stage keeps its word and its entry
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> (valid_s1 && $stable(b_s1) && $stable(bit_s1)))
		else $error("merge stage lost a stalled word");
`endif

endmodule

### design/rpct_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpct_store
// Column store: one 64-bit entry per byte position of a row, one write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module rpct_store
	import rpct_pkg::*;
(
	input  logic               clk,
	input  st_wr_t             wr,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data
);

	logic [ENTRY_W-1:0] mem [STORE_DEPTH];
	logic [ENTRY_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/rpct_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpct_emit
// Column emitter: holds one finished entry and sends its valid column bytes
// one word per cycle while column_ready is high, lowest column first.
// ----------------------------------------------------------------------------
module rpct_emit
	import rpct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_en,
	input  em_load_t          load,
	output logic              free,
	output logic              column_valid,
	input  logic              column_ready,
	output logic [7:0]        column_byte,
	output logic [COL_W-1:0]  column_index,
	output logic [PAGE_W-1:0] page_index,
	output logic              last_of_burst
);

	logic               busy_q;
	logic [ENTRY_W-1:0] data_q;
	logic [COL_W-1:0]   col_q;
	logic [PAGE_W-1:0]  page_q;
	logic [2:0]         left_q;
	logic               fire;
	logic               done;

	assign fire = busy_q && column_ready;
	assign done = fire && (left_q == 3'd0);
	assign free = !busy_q || done;

	// burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load_en) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// burst payload, current column always in the low byte
	always_ff @(posedge clk) begin
		if (load_en) begin
			data_q <= load.data;
			col_q  <= load.col;
			page_q <= load.page;
			left_q <= load.left;
		end else if (fire && !done) begin
			data_q <= {8'h00, data_q[ENTRY_W-1:8]};
			col_q  <= col_q + COL_W'(1);
			left_q <= left_q - 3'd1;
		end
	end

	assign column_valid  = busy_q;
	assign column_byte   = data_q[7:0];
	assign column_index  = col_q;
	assign page_index    = page_q;
	assign last_of_burst = (left_q == 3'd0);

`ifndef SYNTHESIS
	// a new burst never lands on one still being sent
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_en |-> free)
		else $error("emitter loaded while busy");

	// a burst never runs past the last column of its byte
	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !last_of_burst) |-> (col_q[2:0] != 3'd7))
		else $error("burst runs past byte boundary");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raster to page-column transpose. Raster words
// go in through a queue-fed driver, and a clocked predictor builds the column
// words that each accepted word should produce. A monitor checks every column
// word, field by field, against the oldest prediction. Both handshakes idle
// at random. Image size registers are rewritten between phases while the block
// is idle, and the run covers their extremes and out-of-range values.
// ----------------------------------------------------------------------------
module tb_top
	import rpct_pkg::*;
();

	localparam int ITEM_TARGET = 170;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 40;

	// one column word as seen on the output port
	typedef struct packed {
		logic [7:0]        pixels;
		logic [COL_W-1:0]  column;
		logic [PAGE_W-1:0] page;
		logic              last;
	} column_word_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index     = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data      = '0;
	logic                 raster_valid  = 1'b0;
	logic                 raster_ready;
	logic [7:0]           raster_byte   = 8'h00;
	logic                 column_valid;
	logic                 column_ready  = 1'b0;
	logic [7:0]           column_byte;
	logic [COL_W-1:0]     column_index;
	logic [PAGE_W-1:0]    page_index;
	logic                 last_of_burst;

	// stimulus and scoreboard state
	logic [7:0]       raster_pending[$];
	column_word_t     column_expect[$];
	int               raster_gap    = 0;
	int               ready_hold    = 0;
	bit               quiet_phase   = 1'b0;
	int               items_queued  = 0;
	int               words_in      = 0;
	int               words_checked = 0;
	int               cfg_writes    = 0;
	int               err_count     = 0;
	int               cycle_count   = 0;
	logic [CFG_W-1:0] last_width    = 9'd128;

	// predictor copy of the block state, reset values
	logic [63:0]      page_store[STORE_DEPTH];
	int               byte_pos      = 0;
	int               row_pos       = 0;
	logic [CFG_W-1:0] width_reg     = 9'd128;
	logic [CFG_W-1:0] height_reg    = 9'd128;

	raster_to_page_column_transpose i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.raster_valid (raster_valid),
		.raster_ready (raster_ready),
		.raster_byte  (raster_byte),
		.column_valid (column_valid),
		.column_ready (column_ready),
		.column_byte  (column_byte),
		.column_index (column_index),
		.page_index   (page_index),
		.last_of_burst(last_of_burst)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// zero counts as one, anything past the limit saturates
	function automatic int size_in_use(input logic [CFG_W-1:0] value, input int limit);
		if (value == '0) return 1;
		if (int'(value) > limit) return limit;
		return int'(value);
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet_phase || roll < 65) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [CFG_W-1:0] pick_width();
		case ($urandom_range(0, 11))
			0: begin
				return '0;
			end
			1: begin
				return CFG_W'($urandom_range(257, 511));
			end
			2: begin
				return 9'd256;
			end
			3: begin
				return 9'd1;
			end
			default: begin
				return CFG_W'($urandom_range(2, 24));
			end
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_height();
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return 9'd1;
			end
			2: begin
				return 9'h1FF;
			end
			3: begin
				return 9'd256;
			end
			4: begin
				return CFG_W'($urandom_range(41, 255));
			end
			default: begin
				return CFG_W'($urandom_range(8, 40));
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, what);
	endtask

	// merge one raster word into the page and build the column words it completes
	task automatic predict_columns(input logic [7:0] pix);
		int           w;
		int           h;
		int           bpr;
		int           pos;
		int           row;
		int           slot;
		int           x;
		logic [63:0]  entry;
		column_word_t cw;
		column_word_t burst[$];
		w    = size_in_use(width_reg, MAX_WIDTH);
		h    = size_in_use(height_reg, MAX_HEIGHT);
		bpr  = (w + 7) / 8;
		pos  = byte_pos;
		row  = row_pos;
		slot = row % 8;
		if (pos < bpr && pos < STORE_DEPTH) begin
			// first row of a page starts the entry afresh, white pixels set bits
			entry = (slot == 0) ? 64'd0 : page_store[pos];
			for (int k = 0; k < 8; k++) begin
				x = pos * 8 + k;
				if (x < w && !pix[7 - k]) entry[8 * k + slot] = 1'b1;
			end
			page_store[pos] = entry;
			// last row of the page sends the valid columns in order
			if (slot == 7) begin
				for (int k = 0; k < 8; k++) begin
					x = pos * 8 + k;
					if (x < w) begin
						cw.pixels = entry[8 * k +: 8];
						cw.column = COL_W'(x);
						cw.page   = PAGE_W'(row >> 3);
						cw.last   = 1'b0;
						burst.push_back(cw);
					end
				end
				if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
				foreach (burst[i]) column_expect.push_back(burst[i]);
			end
		end
		// row and image position
		if (pos + 1 >= bpr) begin
			byte_pos = 0;
			row_pos  = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			byte_pos = pos + 1;
		end
	endtask

	task automatic check_column();
		column_word_t want;
		if (column_expect.size() == 0) begin
			report_mismatch($sformatf("unexpected column word byte=%h col=%0d page=%0d last=%b",
				column_byte, column_index, page_index, last_of_burst));
		end else begin
			want = column_expect.pop_front();
			if (column_byte !== want.pixels || column_index !== want.column ||
				page_index !== want.page || last_of_burst !== want.last) begin
				report_mismatch($sformatf(
					"got byte=%h col=%0d page=%0d last=%b, want byte=%h col=%0d page=%0d last=%b",
					column_byte, column_index, page_index, last_of_burst,
					want.pixels, want.column, want.page, want.last));
			end
		end
		words_checked++;
	endtask

	task automatic queue_byte(input logic [7:0] value);
		raster_pending.push_back(value);
		items_queued++;
	endtask

	task automatic queue_random_bytes(input int count);
		repeat (count) queue_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH) last_width = value;
	endtask

	// all words sent and all column words back, then let the pipeline settle
	task automatic wait_until_idle();
		do @(posedge clk);
		while (raster_pending.size() != 0 || raster_valid || column_expect.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// raster word driver
	always @(posedge clk) begin
		if (!arst_n) begin
			raster_valid <= 1'b0;
			raster_gap   <= 0;
		end else if (raster_valid && !raster_ready) begin
			// hold the word until it is taken
		end else if (raster_gap != 0) begin
			raster_valid <= 1'b0;
			raster_gap   <= raster_gap - 1;
		end else if (raster_pending.size() != 0) begin
			raster_valid <= 1'b1;
			raster_byte  <= raster_pending.pop_front();
			raster_gap   <= pick_gap();
		end else begin
			raster_valid <= 1'b0;
		end
	end

	// column receiver stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			column_ready <= 1'b0;
			ready_hold   <= 0;
		end else if (ready_hold != 0) begin
			column_ready <= 1'b0;
			ready_hold   <= ready_hold - 1;
		end else begin
			column_ready <= 1'b1;
			ready_hold   <= pick_gap();
		end
	end

	// monitor: register writes, column checks, then prediction of new words
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data;
				end else begin
					height_reg = cfg_data;
				end
				cfg_writes++;
			end
			if (column_valid && column_ready) check_column();
			if (raster_valid && raster_ready) begin
				predict_columns(raster_byte);
				words_in++;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d column words outstanding",
				cycle_count, column_expect.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int bytes_per_row;
		int span;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size: part of row 0, its first byte with column 3 black and column 0 white
		queue_byte(8'h10);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(8'hAA);
		queue_byte(8'h55);
		queue_random_bytes(5);
		wait_until_idle();

		// narrow width leaves the row position past the row end, the next word
		// is dropped; height 9 leaves a one-row page that is never sent
		write_reg(REG_IMAGE_WIDTH, 9'd4);
		write_reg(REG_IMAGE_HEIGHT, 9'd9);
		queue_byte(8'hFF);
		queue_byte(8'h10);
		queue_byte(8'h5F);
		queue_byte(8'h3A);
		queue_byte(8'h10);
		queue_byte(8'h1C);
		queue_byte(8'h70);
		// last row of the page, white padding pixels must not show up
		queue_byte(8'h10);
		queue_byte(8'h00);
		wait_until_idle();

		// saturated width fills every store entry on row 0
		write_reg(REG_IMAGE_WIDTH, 9'h1FF);
		write_reg(REG_IMAGE_HEIGHT, 9'd8);
		queue_random_bytes(STORE_DEPTH);
		wait_until_idle();
		write_reg(REG_IMAGE_WIDTH, 9'd5);
		queue_random_bytes(6);
		wait_until_idle();
		// full width last row with the row counter already past a lowered height
		write_reg(REG_IMAGE_WIDTH, 9'd256);
		write_reg(REG_IMAGE_HEIGHT, 9'd3);
		queue_random_bytes(STORE_DEPTH);

		// random phases: mostly whole rows, sometimes stopping mid-row
		while (items_queued < ITEM_TARGET) begin
			wait_until_idle();
			quiet_phase = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, pick_width());
			if ($urandom_range(0, 2) == 0) write_reg(REG_IMAGE_HEIGHT, pick_height());
			bytes_per_row = (size_in_use(last_width, MAX_WIDTH) + 7) / 8;
			span = bytes_per_row * $urandom_range(2, 10);
			if ($urandom_range(0, 2) == 0) span = span + $urandom_range(0, bytes_per_row);
			if (span > 48) span = 48;
			queue_random_bytes(span);
		end
		quiet_phase = 1'b0;
		wait_until_idle();
		repeat (16) @(posedge clk);

		$display("Sent %0d raster words under %0d register writes, checked %0d column words",
			words_in, cfg_writes, words_checked);
		$display("Sizes ranged from zero and one up to saturated width and height");
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### raster_to_page_column_transpose.f
design/rpct_pkg.sv
design/rpct_store.sv
design/rpct_emit.sv
design/raster_to_page_column_transpose.sv
verif/tb_top.sv
